@@ sv/rkx_pkg.sv @@
package rkx_pkg;

  localparam int KEY_BYTES = 32;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int WORD_BYTES = WORD_W / BYTE_W;
  localparam int KEY_WORDS = KEY_BYTES / WORD_BYTES;
  localparam int KW_IDX_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int POS_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(KEY_BYTES);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_LENGTH = 3'd4
  } cfg_reg_e;

  // zero acts as one, anything past the key size acts as the key size
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_MAX) n = LEN_MAX;
    return n;
  endfunction

endpackage

@@ sv/rkx_if.sv @@
interface rkx_in_if;
  logic            valid;
  logic            ready;
  rkx_pkg::byte_t  plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

interface rkx_out_if;
  logic            valid;
  logic            ready;
  rkx_pkg::byte_t  cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

@@ sv/rotating_key_xor_stream_cipher_top.sv @@
// Rotating-key XOR byte stream cipher.
// in_i  : valid/ready channel, one plain_byte per transfer.
// out_o : valid/ready channel, one cipher_byte per input transfer, in order.
// cfg   : cfg_we_i writes cfg_data_i to register cfg_idx_i (key words 0..3,
//         key length). Any valid write reloads the working key and restarts
//         at key byte 0. Write only while no transfer is in flight.
// Timing: the result is registered in the output (or, in a stall, skid)
//         register. Throughput: one byte per cycle while in_i.ready is high;
//         the XOR, position step and one-bit ring rotate are combinational.
// Stall: a two-entry output buffer (output register plus skid register)
//         lets one more input transfer complete while the receiver holds
//         ready low; in_i.ready drops once the skid register is occupied.
// Reset: key words clear, key length is 1, working key is zero, position 0,
//         both output entries empty. Encryption and decryption are the same.
module rotating_key_xor_stream_cipher_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rkx_in_if.sink                           in_i,
  rkx_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [rkx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rkx_pkg::WORD_W-1:0]       cfg_data_i
);
  import rkx_pkg::*;

  word_t              key_q [KEY_WORDS];
  word_t              key_d [KEY_WORDS];
  logic [LEN_W-1:0]   len_q, len_d, len_eff;
  byte_t              wk_q [KEY_BYTES];
  byte_t              wk_d [KEY_BYTES];
  byte_t              reload_key [KEY_BYTES];
  byte_t              rot_key [KEY_BYTES];
  logic [POS_W-1:0]   pos_q, pos_d, pos_eff;
  logic               cfg_load;
  logic               in_acc, out_take, wrap, top_bit;
  byte_t              result;
  logic               out_valid_q, skid_valid_q;
  byte_t              out_data_q, skid_data_q;

  always_comb begin
    key_d    = key_q;
    len_d    = len_q;
    cfg_load = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
          key_d[cfg_idx_i[KW_IDX_W-1:0]] = cfg_data_i;
          cfg_load = 1'b1;
        end
        REG_KEY_LENGTH: begin
          len_d    = cfg_data_i[LEN_W-1:0];
          cfg_load = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign len_eff = eff_len(len_q);
  assign pos_eff = ({1'b0, pos_q} >= len_eff) ? '0 : pos_q;
  assign wrap    = ({1'b0, pos_eff} + LEN_W'(1)) >= len_eff;
  assign top_bit = wk_q[POS_W'(len_eff - LEN_W'(1))][BYTE_W-1];
  assign result  = in_i.plain_byte ^ wk_q[pos_eff];

  for (genvar b = 0; b < KEY_BYTES; b++) begin : g_byte
    logic carry;
    assign reload_key[b] = key_d[b / WORD_BYTES][(b % WORD_BYTES)*BYTE_W +: BYTE_W];
    if (b == 0) begin : g_first
      assign carry = top_bit;
    end else begin : g_rest
      assign carry = wk_q[b-1][BYTE_W-1];
    end
    assign rot_key[b] = (LEN_W'(b) < len_eff) ? {wk_q[b][BYTE_W-2:0], carry} : wk_q[b];
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_take = out_o.valid && out_o.ready;

  always_comb begin
    wk_d  = wk_q;
    pos_d = pos_q;
    if (cfg_load) begin
      wk_d  = reload_key;
      pos_d = '0;
    end else if (in_acc) begin
      if (wrap) begin
        wk_d  = rot_key;
        pos_d = '0;
      end else begin
        pos_d = pos_eff + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) key_q[i] <= '0;
      for (int i = 0; i < KEY_BYTES; i++) wk_q[i] <= '0;
      len_q <= LEN_RESET;
      pos_q <= '0;
    end else begin
      key_q <= key_d;
      wk_q  <= wk_d;
      len_q <= len_d;
      pos_q <= pos_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_acc) begin
        out_data_q <= result;
      end
    end else if (in_acc) begin
      skid_data_q <= result;
    end
  end

  assign in_i.ready       = !skid_valid_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.cipher_byte = out_data_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < len_eff)
    else $error("key position outside key length");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_load |=> pos_q == '0)
    else $error("position not cleared after register write");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_valid_q && !out_o.ready |=> skid_valid_q)
    else $error("transfer during stall not captured");

  a_drain_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_take |=> out_valid_q && !skid_valid_q)
    else $error("skid entry not moved to output register");

endmodule
